// File: hw/rtl/ntc_code_to_temperature_macros.svh
// Assertion macros shared by the RTL. They expand to nothing in synthesis.
`ifndef NTC_CODE_TO_TEMPERATURE_MACROS_SVH
`define NTC_CODE_TO_TEMPERATURE_MACROS_SVH
`ifndef SYNTHESIS
`define NTC_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("ntc assertion failed");
`define NTC_ASSERT_NEVER(lbl, a) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(a)) \
    else $error("ntc assertion failed");
`else
`define NTC_ASSERT_IMP(lbl, a, b)
`define NTC_ASSERT_NEVER(lbl, a)
`endif
`endif

// File: hw/rtl/ntc_pkg.sv
`default_nettype none
package ntc_pkg;

  localparam int CODE_BITS = 12;
  localparam int RES_W     = 20;
  localparam int BETA_W    = 16;
  localparam int TEMP_W    = 8;
  localparam int ADDR_W    = 4;
  localparam int LN_W      = 21;

  localparam logic [15:0] LN2_Q16 = 16'd45426;
  localparam int KELVIN_CENTI   = 27315;
  localparam int FALLBACK_CENTI = 10000;
  localparam int LOW_CENTI      = -5000;
  localparam int HIGH_CENTI     = 30000;

  typedef enum logic [1:0] {
    REG_SERIES  = 2'd0,
    REG_NOMINAL = 2'd1,
    REG_BETA    = 2'd2,
    REG_TEMP    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic bad;
    logic den_neg;
    logic den_zero;
    logic ovf;
  } flags_t;

  // ln(1 + i/16) in Q16.
  function automatic logic [15:0] ln_tab(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0:  v = 16'd0;
      5'd1:  v = 16'd3973;
      5'd2:  v = 16'd7719;
      5'd3:  v = 16'd11262;
      5'd4:  v = 16'd14624;
      5'd5:  v = 16'd17821;
      5'd6:  v = 16'd20870;
      5'd7:  v = 16'd23783;
      5'd8:  v = 16'd26573;
      5'd9:  v = 16'd29248;
      5'd10: v = 16'd31818;
      5'd11: v = 16'd34292;
      5'd12: v = 16'd36675;
      5'd13: v = 16'd38975;
      5'd14: v = 16'd41197;
      5'd15: v = 16'd43345;
      5'd16: v = 16'd45426;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ntc_ln.sv
`default_nettype none
// Two-stage natural logarithm in Q16: normalize, then table plus interpolation.
module ntc_ln #(
  parameter int W = 20
) (
  input  wire logic                     clk,
  input  wire logic [W-1:0]             x,
  output logic [ntc_pkg::LN_W-1:0]      ln_q16
);
  import ntc_pkg::*;

  logic [4:0]  p_c;
  logic [31:0] norm_c;
  logic [4:0]  p1;
  logic [15:0] f1;
  logic [4:0]  idx;
  logic [15:0] t_lo;
  logic [15:0] t_hi;
  logic [15:0] diff;
  logic [27:0] interp;
  logic [LN_W-1:0] ln_c;

  always_comb begin
    p_c = '0;
    for (int i = 0; i < W; i++) begin
      if (x[i]) begin
        p_c = 5'(i);
      end
    end
    norm_c = 32'(x) << (5'd31 - p_c);
  end

  always_ff @(posedge clk) begin
    p1 <= p_c;
    f1 <= norm_c[30:15];
  end

  always_comb begin
    idx    = {1'b0, f1[15:12]};
    t_lo   = ln_tab(idx);
    t_hi   = ln_tab(idx + 5'd1);
    diff   = t_hi - t_lo;
    interp = 28'(diff) * 28'(f1[11:0]);
    ln_c   = LN_W'(p1) * LN_W'(LN2_Q16) + LN_W'(t_lo) + LN_W'(interp[27:12]);
  end

  always_ff @(posedge clk) begin
    ln_q16 <= ln_c;
  end

endmodule
`default_nettype wire

// File: hw/rtl/ntc_code_to_temperature.sv
`default_nettype none
// NTC thermistor temperature from a divider converter code, by the beta equation.
// One code is taken in every clock cycle (busy is always low). Its result is
// on the result ports, with done high, after it has passed all of the
// pipeline's twenty-four register stages, which are, in order:
// the input stage, two stages in each of the four parallel log units, three
// stages of multiply and add, the overflow check stage, a sixteen-stage
// restoring divider that yields one quotient bit per stage, and the output
// stage. The receiver cannot stall: every result is shown for one cycle only,
// so it must be captured when done is high. A result carries fallback_used
// with the value 100.00 C when the code sits at a rail, a resistance register
// is zero, the equation gives a negative absolute temperature, or the result
// lies below -50.00 C; results above 300.00 C saturate. Configuration
// registers may only be written while no transaction is in flight.
module ntc_code_to_temperature #(
  parameter int CODE_BITS = ntc_pkg::CODE_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [CODE_BITS-1:0]        adc_code,
  output logic                             done,
  output logic signed [15:0]               temperature_centi,
  output logic                             fallback_used,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ntc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import ntc_pkg::*;

  `include "ntc_code_to_temperature_macros.svh"

  localparam int Q_W     = 16;
  localparam int NW      = 57;
  localparam int DW      = 41;
  localparam int LATENCY = 8 + Q_W;

  // Configuration registers.
  logic [RES_W-1:0]         series_resistance;
  logic [RES_W-1:0]         nominal_resistance;
  logic [BETA_W-1:0]        beta_factor;
  logic signed [TEMP_W-1:0] nominal_temp;
  reg_idx_t                 reg_idx;
  logic                     cfg_wr;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_resistance  <= RES_W'(10000);
      nominal_resistance <= RES_W'(10000);
      beta_factor        <= BETA_W'(3950);
      nominal_temp       <= TEMP_W'(25);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SERIES:  series_resistance  <= pwdata[RES_W-1:0];
        REG_NOMINAL: nominal_resistance <= pwdata[RES_W-1:0];
        REG_BETA:    beta_factor        <= pwdata[BETA_W-1:0];
        REG_TEMP:    nominal_temp       <= pwdata[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SERIES:  prdata = 32'(series_resistance);
      REG_NOMINAL: prdata = 32'(nominal_resistance);
      REG_BETA:    prdata = 32'(beta_factor);
      REG_TEMP:    prdata = 32'(nominal_temp);
      default:     prdata = '0;
    endcase
  end

  // Nominal temperature in centikelvin. It is always positive and fits 16 bits.
  logic [16:0] t0c_s;
  logic [15:0] t0c;
  assign t0c_s = {{9{nominal_temp[TEMP_W-1]}}, nominal_temp} * 17'd100 + 17'd27315;
  assign t0c   = t0c_s[15:0];

  // Input stage: capture the code and the divider's other leg.
  logic                 va;
  logic [CODE_BITS-1:0] code_a;
  logic [CODE_BITS-1:0] comp_a;
  logic                 bad_a;

  always_ff @(posedge clk) begin
    code_a <= adc_code;
    comp_a <= {CODE_BITS{1'b1}} - adc_code;
    bad_a  <= (adc_code == '0) || (adc_code == {CODE_BITS{1'b1}}) ||
              (series_resistance == '0) || (nominal_resistance == '0);
  end

  // Four logarithms in parallel, two stages each.
  logic [LN_W-1:0] ln_rs;
  logic [LN_W-1:0] ln_code;
  logic [LN_W-1:0] ln_comp;
  logic [LN_W-1:0] ln_rn;

  ntc_ln #(.W(RES_W)) u_ln_rs (.clk(clk), .x(series_resistance), .ln_q16(ln_rs));
  ntc_ln #(.W(CODE_BITS)) u_ln_code (.clk(clk), .x(code_a), .ln_q16(ln_code));
  ntc_ln #(.W(CODE_BITS)) u_ln_comp (.clk(clk), .x(comp_a), .ln_q16(ln_comp));
  ntc_ln #(.W(RES_W)) u_ln_rn (.clk(clk), .x(nominal_resistance), .ln_q16(ln_rn));

  logic v1, v2, v3, v4, v5, v6;
  logic bad1, bad2, bad3, bad4, bad5;

  // Stage 3: log of the resistance ratio and beta * T0.
  logic signed [22:0] lq_3;
  logic [31:0]        bt_3;
  logic [15:0]        t0c_3;

  always_ff @(posedge clk) begin
    lq_3  <= $signed({2'b0, ln_rs}) + $signed({2'b0, ln_code})
           - $signed({2'b0, ln_comp}) - $signed({2'b0, ln_rn});
    bt_3  <= 32'(beta_factor) * 32'(t0c);
    t0c_3 <= t0c;
  end

  // Stage 4: T0 * L, and the scaled numerator and beta terms.
  logic signed [39:0] prod_4;
  logic [38:0]        num100_4;
  logic [22:0]        beta100_4;

  always_ff @(posedge clk) begin
    prod_4    <= 40'($signed({1'b0, t0c_3})) * 40'(lq_3);
    num100_4  <= 39'(bt_3) * 39'd100;
    beta100_4 <= 23'(beta_factor) * 23'd100;
  end

  // Stage 5: denominator, rounded dividend and divisor.
  logic signed [DW-1:0] den_c;
  logic signed [57:0]   n_c;
  logic [NW-1:0]        n_5;
  logic [DW-1:0]        d_5;
  logic                 den_neg_5;
  logic                 den_zero_5;

  assign den_c = $signed({2'b0, beta100_4, 16'b0}) + DW'(prod_4);
  assign n_c   = $signed({2'b0, num100_4, 17'b0}) + 58'(den_c);

  always_ff @(posedge clk) begin
    n_5        <= n_c[NW-1:0];
    d_5        <= {den_c[DW-2:0], 1'b0};
    den_neg_5  <= den_c[DW-1];
    den_zero_5 <= (den_c == '0);
  end

  // Divider pipeline. Entry 0 is the overflow check stage; a quotient that
  // would need more than sixteen bits is far above the saturation point.
  logic [NW-1:0]  dv_rem [0:Q_W];
  logic [DW-1:0]  dv_d   [0:Q_W];
  logic [Q_W-1:0] dv_q   [0:Q_W];
  flags_t         dv_fl  [0:Q_W];
  logic [Q_W-1:0] dv_vld;
  logic [Q_W-1:0] dv_ge;

  always_ff @(posedge clk) begin
    dv_rem[0] <= n_5;
    dv_d[0]   <= d_5;
    dv_q[0]   <= '0;
    dv_fl[0]  <= '{bad: bad5, den_neg: den_neg_5, den_zero: den_zero_5,
                   ovf: (n_5 >= {d_5, 16'b0})};
  end

  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      dv_ge[k] = dv_rem[k] >= (NW'(dv_d[k]) << (Q_W - 1 - k));
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < Q_W; k++) begin
      dv_rem[k+1] <= dv_ge[k] ? dv_rem[k] - (NW'(dv_d[k]) << (Q_W - 1 - k))
                              : dv_rem[k];
      dv_d[k+1]   <= dv_d[k];
      dv_q[k+1]   <= {dv_q[k][Q_W-2:0], dv_ge[k]};
      dv_fl[k+1]  <= dv_fl[k];
    end
  end

  // Valid bits and the fallback flag travel alongside the data. v6 marks
  // divider entry 0 and dv_vld[k] marks entry k+1.
  always_ff @(posedge clk) begin
    if (rst) begin
      va     <= 1'b0;
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      v4     <= 1'b0;
      v5     <= 1'b0;
      v6     <= 1'b0;
      dv_vld <= '0;
      done   <= 1'b0;
    end else begin
      va     <= start && !busy;
      v1     <= va;
      v2     <= v1;
      v3     <= v2;
      v4     <= v3;
      v5     <= v4;
      v6     <= v5;
      dv_vld <= {dv_vld[Q_W-2:0], v6};
      done   <= dv_vld[Q_W-1];
    end
  end

  always_ff @(posedge clk) begin
    bad1 <= bad_a;
    bad2 <= bad1;
    bad3 <= bad2;
    bad4 <= bad3;
    bad5 <= bad4;
  end

  // Output stage: back to Celsius, then the special cases in priority order.
  logic signed [17:0] res_c;
  flags_t             fl;
  logic               fb_c;
  logic signed [15:0] temp_c;

  assign fl    = dv_fl[Q_W];
  assign res_c = $signed({2'b0, dv_q[Q_W]}) - 18'sd27315;

  always_comb begin
    fb_c   = 1'b0;
    temp_c = res_c[15:0];
    if (fl.bad || fl.den_neg) begin
      fb_c = 1'b1;
    end else if (fl.den_zero || fl.ovf) begin
      temp_c = 16'(HIGH_CENTI);
    end else if (res_c < 18'(LOW_CENTI)) begin
      fb_c = 1'b1;
    end else if (res_c > 18'(HIGH_CENTI)) begin
      temp_c = 16'(HIGH_CENTI);
    end
    if (fb_c) begin
      temp_c = 16'(FALLBACK_CENTI);
    end
  end

  always_ff @(posedge clk) begin
    temperature_centi <= temp_c;
    fallback_used     <= fb_c;
  end

  // A flagged transaction always carries the fallback value.
  `NTC_ASSERT_IMP(a_fallback_value, done && fallback_used,
                  temperature_centi == 16'sd10000)
  // An unflagged result stays inside the reported range.
  `NTC_ASSERT_NEVER(a_result_range, done && !fallback_used &&
                    (temperature_centi > 16'sd30000 || temperature_centi < -16'sd5000))
  // Every result traces back to an accepted code, checked with the LATENCY delay.
  `NTC_ASSERT_IMP(a_latency, done, $past(start && !busy, LATENCY))

endmodule
`default_nettype wire
